[hw/rtl/brc_pkg.sv]
package brc_pkg;

	// Default table size.
	localparam int REGIONS_DEF = 16;
	localparam int DIMS_DEF    = 8;

	// Q1.15 limits: -1.0 is exact, +1.0 saturates to the largest code.
	localparam logic signed [15:0] Q_MINUS_ONE = 16'sh8000;
	localparam logic signed [15:0] Q_PLUS_ONE  = 16'sh7FFF;

	// Region index reported when no box matches.
	localparam logic [4:0] IDX_NONE = 5'h1F;

	// Reset value of the dimension count register.
	localparam logic [3:0] DIMS_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_SPLIT = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_COPY,
		ST_QUERY,
		ST_RESULT
	} state_t;

	// One memory word holds both bounds of one region in one dimension.
	typedef struct packed {
		logic signed [15:0] upper;
		logic signed [15:0] lower;
	} bound_t;

endpackage

[hw/rtl/box_region_classifier_top.sv]
// Box region classifier: a table of axis-aligned boxes with an inclusive Q1.15 lower and
// upper bound per dimension, matched against query vectors fed one coordinate at a time.
// The input stream carries the operation in s_axis_tuser and the coordinate-done mark in
// s_axis_tlast. Init writes a full-range box, split copies a parent box into a child slot
// and cuts one dimension, and a query coordinate trims the set of still-matching boxes.
// The coordinate that carries tlast produces one result transfer on the output stream: the
// found flag in m_axis_tuser and the lowest matching slot (or -1) in m_axis_tdata. The cfg
// port sets the compared dimension count; the user writes it only while idle, unenforced.
// Flow: one transfer is taken, then the block is busy. Init writes one word per dimension
// and a split copies one per dimension, set by the single port pair of the bound memory
// (one word read and one written per cycle). A query coordinate walks the regions one per
// cycle through the shared bound comparator and, when tlast is set, then hands the result
// to the output register. Coordinates outside the compared dimensions without tlast,
// unused operations and out-of-range slots are dropped in the accepting cycle.
// The result sits in an output register: a stalled receiver holds it there while the next
// item is taken, and only the next result waits for the register to drain.
// Reset clears the valid marks, fills the match set and loads eight compared dimensions; the
// bound memory is not cleared and needs no sweep, since a box is written before it is valid.
module box_region_classifier_top #(
	parameter int REGIONS = brc_pkg::REGIONS_DEF,
	parameter int DIMS    = brc_pkg::DIMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration: dims_in_use.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// region [3:0], parent [7:4], dim [10:8], value [26:11], first_half [27], zero [31:28]
	input  logic [31:0] s_axis_tdata,
	// op [1:0]
	input  logic [1:0]  s_axis_tuser,
	// last
	input  logic        s_axis_tlast,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// region_index [4:0], zero [7:5]
	output logic [7:0]  m_axis_tdata,
	// found
	output logic        m_axis_tuser
);

	localparam int DEPTH = REGIONS * DIMS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int MAXN  = (REGIONS > DIMS) ? REGIONS : DIMS;
	localparam int SW    = $clog2(MAXN + 1);

	// Input fields.
	logic [3:0]         in_region;
	logic [3:0]         in_parent;
	logic [2:0]         in_dim;
	logic signed [15:0] in_value;
	logic               in_first_half;

	assign in_region     = s_axis_tdata[3:0];
	assign in_parent     = s_axis_tdata[7:4];
	assign in_dim        = s_axis_tdata[10:8];
	assign in_value      = s_axis_tdata[26:11];
	assign in_first_half = s_axis_tdata[27];

	brc_pkg::state_t state_q, state_nx;

	logic [3:0]         dims_q;
	logic [SW-1:0]      step_q, step_s1;
	logic               vld_s1;
	logic [AW-1:0]      rd_addr_q, wr_addr_q;
	logic signed [15:0] value_q;
	logic               last_q, cmp_en_q, cut_en_q, first_half_q;
	logic [2:0]         cut_dim_q;
	logic [3:0]         region_q;
	logic               found_q;
	logic [4:0]         idx_q;
	logic [REGIONS-1:0] valid_q, still_q;
	logic               out_vld_q, out_found_q;
	logic [4:0]         out_idx_q;

	logic               accept;
	logic               slot_ok, parent_ok, cmp_en_in;
	logic [3:0]         act_dims;
	logic [SW-1:0]      lim, lim_m1;
	logic               issue, done_s1, init_done;
	logic               mem_we, mem_re;
	brc_pkg::bound_t    mem_wdata, mem_rdata;
	logic [RW-1:0]      r_s1;
	logic               miss_s1, match_s1;
	logic               out_load;

	assign cfg_ready = 1'b1;
	assign accept    = s_axis_tvalid && s_axis_tready;

	assign slot_ok   = int'(in_region) < REGIONS;
	assign parent_ok = int'(in_parent) < REGIONS;
	assign act_dims  = (int'(dims_q) > DIMS) ? 4'(DIMS) : dims_q;
	assign cmp_en_in = {1'b0, in_dim} < act_dims;

	// Pass length: one word per dimension for box writes, one per region for queries.
	assign lim    = (state_q == brc_pkg::ST_QUERY) ? SW'(REGIONS) : SW'(DIMS);
	assign lim_m1 = lim - SW'(1);

	assign done_s1   = vld_s1 && (step_s1 == lim_m1);
	assign init_done = (state_q == brc_pkg::ST_INIT) && issue && (step_q == lim_m1);
	assign out_load  = (state_q == brc_pkg::ST_RESULT) && (!out_vld_q || m_axis_tready);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			brc_pkg::ST_IDLE: begin
				if (accept) begin
					case (brc_pkg::op_t'(s_axis_tuser))
						brc_pkg::OP_INIT: begin
							if (slot_ok) state_nx = brc_pkg::ST_INIT;
						end
						brc_pkg::OP_SPLIT: begin
							if (slot_ok && parent_ok) state_nx = brc_pkg::ST_COPY;
						end
						brc_pkg::OP_QUERY: begin
							if (cmp_en_in || s_axis_tlast) state_nx = brc_pkg::ST_QUERY;
						end
						default: state_nx = brc_pkg::ST_IDLE;
					endcase
				end
			end
			brc_pkg::ST_INIT: begin
				if (init_done) state_nx = brc_pkg::ST_IDLE;
			end
			brc_pkg::ST_COPY: begin
				if (done_s1) state_nx = brc_pkg::ST_IDLE;
			end
			brc_pkg::ST_QUERY: begin
				if (done_s1) state_nx = last_q ? brc_pkg::ST_RESULT : brc_pkg::ST_IDLE;
			end
			brc_pkg::ST_RESULT: begin
				if (out_load) state_nx = brc_pkg::ST_IDLE;
			end
			default: state_nx = brc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		issue         = 1'b0;
		mem_re        = 1'b0;
		mem_we        = 1'b0;
		mem_wdata     = mem_rdata;
		case (state_q)
			brc_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			brc_pkg::ST_INIT: begin
				issue           = step_q < lim;
				mem_we          = issue;
				mem_wdata.upper = brc_pkg::Q_PLUS_ONE;
				mem_wdata.lower = brc_pkg::Q_MINUS_ONE;
			end
			brc_pkg::ST_COPY: begin
				issue  = step_q < lim;
				mem_re = issue;
				mem_we = vld_s1;
				if (cut_en_q && (step_s1 == SW'(cut_dim_q))) begin
					if (first_half_q) begin
						mem_wdata.upper = value_q;
					end else begin
						mem_wdata.lower = value_q;
					end
				end
			end
			brc_pkg::ST_QUERY: begin
				issue  = step_q < lim;
				mem_re = issue && cmp_en_q;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// Shared bound comparator on the word read for the region in the compare stage.
	assign r_s1     = step_s1[RW-1:0];
	assign miss_s1  = cmp_en_q && ((mem_rdata.lower > value_q) || (mem_rdata.upper < value_q));
	assign match_s1 = valid_q[r_s1] && still_q[r_s1] && !miss_s1;

	brc_bound_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr_q),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_addr_q),
		.rdata (mem_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= brc_pkg::ST_IDLE;
			dims_q    <= brc_pkg::DIMS_RESET;
			vld_s1    <= 1'b0;
			valid_q   <= '0;
			still_q   <= '1;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= issue;
			if (cfg_valid && cfg_ready) begin
				dims_q <= cfg_data;
			end
			if (accept) begin
				found_q <= 1'b0;
			end
			if (init_done || ((state_q == brc_pkg::ST_COPY) && done_s1)) begin
				valid_q[RW'(region_q)] <= 1'b1;
			end
			if ((state_q == brc_pkg::ST_QUERY) && vld_s1) begin
				// The match set starts over once the last coordinate has been scored.
				if (done_s1 && last_q) begin
					still_q <= '1;
				end else if (valid_q[r_s1] && miss_s1) begin
					still_q[r_s1] <= 1'b0;
				end
				if (match_s1 && !found_q) begin
					found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload and address registers.
	always_ff @(posedge clk) begin
		step_s1 <= step_q;
		if (accept) begin
			step_q       <= '0;
			value_q      <= in_value;
			last_q       <= s_axis_tlast;
			cmp_en_q     <= cmp_en_in;
			cut_en_q     <= int'(in_dim) < DIMS;
			cut_dim_q    <= in_dim;
			first_half_q <= in_first_half;
			region_q     <= in_region;
			wr_addr_q    <= AW'(int'(in_region) * DIMS);
			if (brc_pkg::op_t'(s_axis_tuser) == brc_pkg::OP_SPLIT) begin
				rd_addr_q <= AW'(int'(in_parent) * DIMS);
			end else begin
				rd_addr_q <= AW'(in_dim);
			end
		end else begin
			if (issue) begin
				step_q <= step_q + SW'(1);
				if (state_q == brc_pkg::ST_QUERY) begin
					rd_addr_q <= rd_addr_q + AW'(DIMS);
				end else begin
					rd_addr_q <= rd_addr_q + AW'(1);
				end
			end
			if (mem_we) begin
				wr_addr_q <= wr_addr_q + AW'(1);
			end
		end
		if ((state_q == brc_pkg::ST_QUERY) && vld_s1 && match_s1 && !found_q) begin
			idx_q <= 5'(r_s1);
		end
		if (out_load) begin
			out_found_q <= found_q;
			out_idx_q   <= found_q ? idx_q : brc_pkg::IDX_NONE;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {3'b000, out_idx_q};

	// The bound memory is written only by init and split passes.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == brc_pkg::ST_INIT) || (state_q == brc_pkg::ST_COPY)))
		else $error("bound memory written outside an init or split pass");

	// A finished query has already restored the full match set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == brc_pkg::ST_RESULT) |-> (&still_q))
		else $error("match set not restored after the last coordinate");

	// A result without a match carries the no-match index.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[4:0] == brc_pkg::IDX_NONE))
		else $error("no-match result with a region index");

	// The compare stage only holds words read during a busy pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ($past(state_q) != brc_pkg::ST_IDLE))
		else $error("compare stage loaded while idle");

endmodule

[hw/rtl/brc_bound_mem.sv]
module brc_bound_mem #(
	parameter int DEPTH = brc_pkg::REGIONS_DEF * brc_pkg::DIMS_DEF,
	parameter int AW    = 7
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  brc_pkg::bound_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output brc_pkg::bound_t rdata
);

	brc_pkg::bound_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data is held when no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
